FILE: rtl/fpa_pkg.sv
// ---------------------------------------------------------------------------
// fpa_pkg: shared types and constants for the fixed-point ALU
// Operation codes, payload structs and default parameters.
// ---------------------------------------------------------------------------
package fpa_pkg;

   localparam int FRAC_BITS_DEFAULT = 8;
   localparam int WORD_BITS_DEFAULT = 32;
   localparam int KIND_BITS = 4;

   typedef enum logic [KIND_BITS-1:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_CMP      = 4'd4,
      OP_MIN      = 4'd5,
      OP_MAX      = 4'd6,
      OP_INC      = 4'd7,
      OP_DEC      = 4'd8,
      OP_FROM_INT = 4'd9,
      OP_TO_INT   = 4'd10
   } op_type;

   typedef struct packed {
      logic [3:0]   kind;
      logic [31:0]  operand_a;
      logic [31:0]  operand_b;
   } req_type;

   typedef struct packed {
      logic [31:0]  result_value;
      logic         is_less;
      logic         is_equal;
      logic         is_greater;
      logic         divide_by_zero;
   } rsp_type;

   // per-item context that rides alongside the divider chain
   typedef struct packed {
      logic [3:0]   kind;
      logic         neg;
      logic         dz;
      logic         is_less;
      logic         is_equal;
      logic         is_greater;
      logic [31:0]  fast_value;
   } ctx_type;

endpackage

FILE: rtl/fixed_point_alu.sv
// ---------------------------------------------------------------------------
// fixed_point_alu: signed Q(32-F).F fixed-point ALU
// Pipelined: add/sub/min/max/shift in the front, multiplier alongside,
// divide through a chain of restoring cells, one quotient bit per cell.
// ---------------------------------------------------------------------------
//  channel   ports                 payload
//  request   req_valid/req_ready   req_data  (kind, operand_a, operand_b)
//  response  rsp_valid/rsp_ready   rsp_data  (result_value, flags)
//
//  Every item passes 32+FRAC_BITS+1 registers (one cell per dividend bit
//  plus the output register). All kinds travel the same chain.
//  One item is accepted per cycle while the output is not stalled.
//  A stalled output holds the whole chain
//  (ready = !out_valid || rsp_ready). Reset clears only valid bits.
module fixed_point_alu #(
   parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fpa_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fpa_pkg::rsp_type  rsp_data
);

   localparam int NUM_BITS = 32 + FRAC_BITS;
   localparam int DEPTH    = NUM_BITS;

   logic stall;
   logic               v   [DEPTH+1];
   logic [NUM_BITS-1:0] num [DEPTH+1];
   logic [31:0]        den [DEPTH+1];
   logic [31:0]        rem [DEPTH+1];
   fpa_pkg::ctx_type   ctx [DEPTH+1];
   logic [31:0]        mag_a, mag_b;

   // multiplier: registered product, then carried along in a shift line
   logic [63:0]        prod_ff;
   logic [63:0]        pline_ff [DEPTH];
   logic               out_valid_ff;
   fpa_pkg::rsp_type   out_ff, out_in;

   assign stall     = out_valid_ff && !rsp_ready;
   assign req_ready = !stall;

   fpa_front #(.FRAC_BITS(FRAC_BITS), .NUM_BITS(NUM_BITS)) u_front (
      .req_i(req_data), .ctx_o(ctx[0]), .num_o(num[0]), .den_o(den[0]),
      .mag_a_o(mag_a), .mag_b_o(mag_b)
   );
   assign v[0]   = req_valid;
   assign rem[0] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      fpa_div_cell #(.NUM_BITS(NUM_BITS), .DEN_BITS(32)) u_cell (
         .clock(clock), .reset(reset), .valid_i(v[i]), .stall_i(stall),
         .num_i(num[i]), .den_i(den[i]), .rem_i(rem[i]), .ctx_i(ctx[i]),
         .valid_o(v[i+1]), .num_o(num[i+1]), .den_o(den[i+1]),
         .rem_o(rem[i+1]), .ctx_o(ctx[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         prod_ff     <= mag_a * mag_b;
         pline_ff[0] <= prod_ff;
         for (int i = 1; i < DEPTH; i++) pline_ff[i] <= pline_ff[i-1];
      end
   end

   logic [63:0] sprod;
   logic [63:0] pshift;
   logic [NUM_BITS-1:0] q;
   logic [31:0] qs;

   // product register lines up with the first cell, so pline_ff[DEPTH-2]
   // lines up with the last cell, which feeds the output register
   always_comb begin
      fpa_pkg::ctx_type c;
      c      = ctx[DEPTH];
      sprod  = c.neg ? 64'(-pline_ff[DEPTH-2]) : pline_ff[DEPTH-2];
      pshift = 64'($signed(sprod) >>> FRAC_BITS);
      q      = num[DEPTH];
      qs     = c.neg ? 32'(-q[31:0]) : q[31:0];
      out_in.is_less        = c.is_less;
      out_in.is_equal       = c.is_equal;
      out_in.is_greater     = c.is_greater;
      out_in.divide_by_zero = c.dz;
      priority if (c.kind == fpa_pkg::OP_MUL) begin
         out_in.result_value = pshift[31:0];
      end else if (c.kind == fpa_pkg::OP_DIV) begin
         out_in.result_value = c.dz ? 32'd0 : qs;
      end else begin
         out_in.result_value = c.fast_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!stall) begin
         out_valid_ff <= v[DEPTH];
      end
      if (!stall) out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");
   a_dz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.divide_by_zero |-> rsp_data.result_value == 32'd0)
      else $error("divide by zero gave nonzero result");
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({rsp_data.is_less, rsp_data.is_equal, rsp_data.is_greater}))
      else $error("compare flags not exclusive");

endmodule

FILE: rtl/fpa_div_cell.sv
// ---------------------------------------------------------------------------
// fpa_div_cell: one stage of the restoring divider chain
// Shifts one dividend bit into the remainder, subtracts the divisor when
// it fits, and hands the partial state on to the next cell.
// ---------------------------------------------------------------------------
module fpa_div_cell #(
   parameter int NUM_BITS = 40,
   parameter int DEN_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 valid_i,
   input  logic                 stall_i,
   input  logic [NUM_BITS-1:0]  num_i,
   input  logic [DEN_BITS-1:0]  den_i,
   input  logic [DEN_BITS-1:0]  rem_i,
   input  fpa_pkg::ctx_type     ctx_i,
   output logic                 valid_o,
   output logic [NUM_BITS-1:0]  num_o,
   output logic [DEN_BITS-1:0]  den_o,
   output logic [DEN_BITS-1:0]  rem_o,
   output fpa_pkg::ctx_type     ctx_o
);

   logic                 valid_ff;
   logic [NUM_BITS-1:0]  num_ff, num_in;
   logic [DEN_BITS-1:0]  den_ff;
   logic [DEN_BITS-1:0]  rem_ff, rem_in;
   fpa_pkg::ctx_type     ctx_ff;
   logic [DEN_BITS:0]    trial;
   logic [DEN_BITS:0]    diff;

   // num holds the remaining dividend bits in its top and the quotient in
   // its bottom; each cell moves one bit across
   always_comb begin
      trial  = {rem_i, num_i[NUM_BITS-1]};
      diff   = trial - {1'b0, den_i};
      num_in = {num_i[NUM_BITS-2:0], ~diff[DEN_BITS]};
      rem_in = diff[DEN_BITS] ? trial[DEN_BITS-1:0] : diff[DEN_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!stall_i) begin
         valid_ff <= valid_i;
      end
      if (!stall_i) begin
         num_ff <= num_in;
         den_ff <= den_i;
         rem_ff <= rem_in;
         ctx_ff <= ctx_i;
      end
   end

   assign valid_o = valid_ff;
   assign num_o   = num_ff;
   assign den_o   = den_ff;
   assign rem_o   = rem_ff;
   assign ctx_o   = ctx_ff;

endmodule

FILE: rtl/fpa_front.sv
// ---------------------------------------------------------------------------
// fpa_front: operand decode and combinational operations
// Computes flags, the simple results, the product and divider operands.
// ---------------------------------------------------------------------------
module fpa_front #(
   parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEFAULT,
   parameter int NUM_BITS  = 40
) (
   input  fpa_pkg::req_type     req_i,
   output fpa_pkg::ctx_type     ctx_o,
   output logic [NUM_BITS-1:0]  num_o,
   output logic [31:0]          den_o,
   output logic [31:0]          mag_a_o,
   output logic [31:0]          mag_b_o
);

   logic signed [31:0] a, b;
   logic [31:0]        r;
   logic               lt;

   always_comb begin
      a  = signed'(req_i.operand_a);
      b  = signed'(req_i.operand_b);
      lt = a < b;
      unique case (req_i.kind)
         fpa_pkg::OP_ADD:      r = a + b;
         fpa_pkg::OP_SUB:      r = a - b;
         fpa_pkg::OP_MIN:      r = lt ? a : b;
         fpa_pkg::OP_MAX:      r = (a > b) ? a : b;
         fpa_pkg::OP_INC:      r = a + 32'sd1;
         fpa_pkg::OP_DEC:      r = a - 32'sd1;
         fpa_pkg::OP_FROM_INT: r = a <<< FRAC_BITS;
         fpa_pkg::OP_TO_INT:   r = a >>> FRAC_BITS;
         default:              r = '0;
      endcase
      mag_a_o = a[31] ? 32'(-a) : a;
      mag_b_o = b[31] ? 32'(-b) : b;
      ctx_o.kind       = req_i.kind;
      ctx_o.neg        = a[31] ^ b[31];
      ctx_o.dz         = (req_i.kind == fpa_pkg::OP_DIV) && (b == 0);
      ctx_o.is_less    = lt;
      ctx_o.is_equal   = a == b;
      ctx_o.is_greater = a > b;
      ctx_o.fast_value = r;
      num_o = NUM_BITS'({mag_a_o, {FRAC_BITS{1'b0}}});
      den_o = mag_b_o;
   end

endmodule
